// File: rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor engine.
// Holds the request/response beat structs and the controller/datapath link.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

	// Request kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'd1;

	// Color reset values
	localparam logic [3:0] FG_RESET = 4'hF;
	localparam logic [3:0] BG_RESET = 4'h0;

	// Control bytes and blank cell
	localparam logic [7:0]  CHAR_BS    = 8'h08;
	localparam logic [7:0]  CHAR_TAB   = 8'h09;
	localparam logic [7:0]  CHAR_LF    = 8'h0A;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [15:0] RESET_CELL = 16'h0F20;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} req_item_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_index;
		logic [15:0] cell_data;
		logic        scrolled;
	} rsp_item_t;

	// Screen sweep operations driven by the controller
	typedef enum logic [2:0] {
		SW_NONE,
		SW_INIT,
		SW_CLEAR,
		SW_COPY,
		SW_FILL
	} sweep_op_t;

	typedef struct packed {
		logic      capture;
		logic      put;
		logic      read;
		logic      home;
		logic      load_result;
		sweep_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       put_scroll;
		logic       copy_last;
		logic       sweep_last;
		logic       rsp_free;
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/tcc_datapath.sv
// Datapath: screen memory, cursor, color registers, sweep pointer and response register.
// Depends on tcc_pkg; driven by tcc_controller through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tcc_datapath
	import tcc_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire req_item_t              req_item,
	output      logic                   rsp_valid,
	input  wire logic                   rsp_stall,
	output      rsp_item_t              rsp_item,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire dp_cmd_t                cmd,
	output      dp_status_t             sts
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(COLUMNS);
	localparam int YW    = $clog2(ROWS);

	localparam logic [XW-1:0] X_RESET     = XW'(10 % COLUMNS);
	localparam logic [XW:0]   COLS_X      = (XW+1)'(COLUMNS);
	localparam logic [YW:0]   ROWS_Y      = (YW+1)'(ROWS);
	localparam logic [YW-1:0] Y_LAST      = YW'(ROWS - 1);
	localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST_A = AW'(CELLS - COLUMNS - 1);

	logic [15:0]   mem [CELLS];

	req_item_t     item_q;
	logic [XW-1:0] cursor_x_q;
	logic [YW-1:0] cursor_y_q;
	logic [3:0]    fg_q;
	logic [3:0]    bg_q;
	logic [AW-1:0] ptr_q;
	logic          copy_s1;
	logic [AW-1:0] dst_s1;
	logic [15:0]   rdata_q;
	logic          scrolled_q;
	logic          rsp_valid_q;
	rsp_item_t     rsp_item_q;

	logic [XW:0]   x_ext;
	logic [XW:0]   nx;
	logic [YW:0]   ny;
	logic          write_char;
	logic          put_scroll;
	logic [YW-1:0] next_y;
	logic [AW-1:0] cur_idx;
	logic [15:0]   blank;
	logic [31:0]   addr_ext;
	logic          in_range;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [31:0]   x_out;
	logic [31:0]   y_out;
	logic [31:0]   idx_out;

	assign blank    = {bg_q, fg_q, CHAR_SPACE};
	assign cur_idx  = AW'(cursor_y_q) * COLS_A + AW'(cursor_x_q);
	assign addr_ext = 32'(item_q.cell_address);
	assign in_range = addr_ext < 32'(CELLS);

	// Next cursor position for a put
	always_comb begin
		x_ext      = {1'b0, cursor_x_q};
		nx         = x_ext;
		ny         = {1'b0, cursor_y_q};
		write_char = 1'b0;
		unique case (item_q.char_code)
			CHAR_BS: begin
				if (x_ext != '0) nx = x_ext - 1'b1;
			end
			CHAR_TAB: nx = (x_ext + (XW+1)'(8)) & ~(XW+1)'(7);
			CHAR_CR:  nx = '0;
			CHAR_LF: begin
				nx = '0;
				ny = ny + 1'b1;
			end
			default: begin
				if (item_q.char_code >= CHAR_SPACE) begin
					write_char = 1'b1;
					nx         = x_ext + 1'b1;
				end
			end
		endcase
		// wrap at the right edge
		if (nx >= COLS_X) begin
			nx = '0;
			ny = ny + 1'b1;
		end
	end

	assign put_scroll = ny >= ROWS_Y;
	assign next_y     = put_scroll ? Y_LAST : ny[YW-1:0];

	// Memory port selection: a pending copy write wins, the controller keeps others apart
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = blank;
		if (copy_s1) begin
			we    = 1'b1;
			waddr = dst_s1;
			wdata = rdata_q;
		end else begin
			unique case (cmd.op)
				SW_INIT: begin
					we    = 1'b1;
					wdata = RESET_CELL;
				end
				SW_CLEAR, SW_FILL: we = 1'b1;
				default: begin
					we    = cmd.put && write_char;
					waddr = cur_idx;
					wdata = {bg_q, fg_q, item_q.char_code};
				end
			endcase
		end
	end

	assign re    = (cmd.op == SW_COPY) || cmd.read;
	assign raddr = (cmd.op == SW_COPY) ? ptr_q + COLS_A : addr_ext[AW-1:0];

	// Screen memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= req_item;
		dst_s1 <= ptr_q;
		if (cmd.load_result) rsp_item_q <= '{
			cursor_column: x_out[6:0],
			cursor_row:    y_out[4:0],
			cursor_index:  idx_out[10:0],
			cell_data:     (item_q.kind == KIND_READ && in_range) ? rdata_q : 16'h0000,
			scrolled:      scrolled_q
		};
	end

	assign x_out   = 32'(cursor_x_q);
	assign y_out   = 32'(cursor_y_q);
	assign idx_out = 32'(cur_idx);

	// Control state: cursor, colors, sweep pointer, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= X_RESET;
			cursor_y_q  <= '0;
			fg_q        <= FG_RESET;
			bg_q        <= BG_RESET;
			ptr_q       <= '0;
			copy_s1     <= 1'b0;
			scrolled_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_FOREGROUND: fg_q <= cfg_data;
					REG_BACKGROUND: bg_q <= cfg_data;
				endcase
			end
			copy_s1 <= (cmd.op == SW_COPY);
			if (cmd.capture) begin
				ptr_q      <= '0;
				scrolled_q <= 1'b0;
			end else if (cmd.op != SW_NONE) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.put) begin
				cursor_x_q <= nx[XW-1:0];
				cursor_y_q <= next_y;
				scrolled_q <= put_scroll;
			end else if (cmd.home) begin
				cursor_x_q <= '0;
				cursor_y_q <= '0;
			end
			if (cmd.load_result) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	assign sts = '{
		kind:       item_q.kind,
		put_scroll: put_scroll,
		copy_last:  ptr_q == COPY_LAST_A,
		sweep_last: ptr_q == LAST_A,
		rsp_free:   !rsp_valid_q || !rsp_stall
	};

endmodule

`default_nettype wire

// File: rtl/tcc_controller.sv
// Controller: sequences decode, put, read, scroll and clear sweeps for one request at a time.
// Depends on tcc_pkg; drives tcc_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tcc_controller
	import tcc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output      logic       req_stall,
	output      dp_cmd_t    cmd,
	input  wire dp_status_t sts
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_PUT,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_CLEAR,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					unique case (sts.kind)
						KIND_PUT:   state_q <= ST_PUT;
						KIND_CLEAR: state_q <= ST_CLEAR;
						KIND_READ:  state_q <= ST_READ;
						default:    state_q <= ST_DONE;
					endcase
				end
				ST_PUT:   state_q <= sts.put_scroll ? ST_COPY : ST_DONE;
				ST_COPY: begin
					if (sts.copy_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FILL;
				ST_FILL: begin
					if (sts.sweep_last) state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (sts.sweep_last) state_q <= ST_DONE;
				end
				ST_READ:  state_q <= ST_DONE;
				ST_DONE: begin
					if (sts.rsp_free) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_INIT;
			endcase
		end
	end

	// Commands decoded from state
	always_comb begin
		cmd             = '0;
		cmd.op          = SW_NONE;
		cmd.capture     = (state_q == ST_IDLE) && req_valid;
		cmd.put         = (state_q == ST_PUT);
		cmd.read        = (state_q == ST_READ);
		cmd.home        = (state_q == ST_CLEAR);
		cmd.load_result = (state_q == ST_DONE) && sts.rsp_free;
		unique case (state_q)
			ST_INIT:  cmd.op = SW_INIT;
			ST_COPY:  cmd.op = SW_COPY;
			ST_FILL:  cmd.op = SW_FILL;
			ST_CLEAR: cmd.op = SW_CLEAR;
			default:  cmd.op = SW_NONE;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_engine.sv
// Text console cursor engine top level: screen of COLUMNS x ROWS cells plus cursor.
// Depends on tcc_pkg, tcc_controller and tcc_datapath.
//
// Usage:
//   Request channel (req_valid/req_stall/req_item): kind put, clear or read, with the
//   byte to put and the cell address to read. A beat moves when valid is high and stall
//   is low. Response channel (rsp_valid/rsp_stall/rsp_item): one beat per request with
//   the cursor after the request, the cell read and the scroll flag.
//   Color registers are written through cfg_write_en/cfg_index/cfg_data while idle.
// Sweeps:
//   put without scroll, read and unused kind: no sweep.
//   put with scroll: the rows move up by one and the last row is blanked
//   (one cell moved or blanked per cycle).
//   clear: every cell blanked (one cell blanked per cycle), cursor to column 0 row 0.
//   The single-port write of the screen memory sets the sweep length.
// Reset: cursor at column 10 row 0, foreground 15, background 0. After reset a clearing
//   pass fills every cell with 0x0F20; requests are stalled meanwhile.
// Stall: a finished response waits in its output register; the engine holds the next
//   finished request until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine
	import tcc_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output      logic                   req_stall,
	input  wire req_item_t              req_item,
	output      logic                   rsp_valid,
	input  wire logic                   rsp_stall,
	output      rsp_item_t              rsp_item,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	// Sequencer
	tcc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Screen memory, cursor and response register
	tcc_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_item     (req_item),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_item     (rsp_item),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

// File: sim/text_console_cursor_engine_test.sv
// Self-checking bench for text_console_cursor_engine: directed table then random traffic.
// Predicts responses from a screen/cursor copy or the directed table; depends on tcc_pkg and the RTL.
`timescale 1ns / 1ps

module text_console_cursor_engine_test;
	import tcc_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Kind code the block must pass through untouched
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 280;
	localparam int DIR_STEPS    = 28;
	localparam int DRAIN_CYCLES = 50;

	typedef struct packed {
		req_item_t req;
		logic      fixed;
		rsp_item_t rsp;
	} directed_row_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      req_valid    = 1'b0;
	logic      req_stall;
	req_item_t req_item     = '0;
	logic      rsp_valid;
	logic      rsp_stall    = 1'b0;
	rsp_item_t rsp_item;
	logic      cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_FOREGROUND;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Console copy used for prediction
	logic [15:0] screen_copy [0:CELLS-1];
	int          cur_x;
	int          cur_y;
	logic [3:0]  fg_copy;
	logic [3:0]  bg_copy;

	rsp_item_t     awaited_rsps [$];
	directed_row_t directed_steps [0:DIR_STEPS-1];
	int unsigned   mismatch_count = 0;
	int            burst_left = 0;
	int            stall_mode = 0;
	int            stall_run  = 0;

	text_console_cursor_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_item    (req_item),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_item    (rsp_item),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one request to the console copy and return the cursor report it causes
	function automatic rsp_item_t console_step(input req_item_t it);
		rsp_item_t   r;
		logic [15:0] blank;
		r     = '0;
		blank = {bg_copy, fg_copy, CHAR_SPACE};
		case (it.kind)
			KIND_PUT: begin
				if (it.char_code == CHAR_BS) begin
					if (cur_x != 0)
						cur_x--;
				end else if (it.char_code == CHAR_TAB) begin
					cur_x = (cur_x + 8) & ~7;
				end else if (it.char_code == CHAR_CR) begin
					cur_x = 0;
				end else if (it.char_code == CHAR_LF) begin
					cur_x = 0;
					cur_y++;
				end else if (it.char_code >= CHAR_SPACE) begin
					screen_copy[cur_y * COLUMNS + cur_x] = {blank[15:8], it.char_code};
					cur_x++;
				end
				// wrap at the right edge, scroll below the last row
				if (cur_x >= COLUMNS) begin
					cur_x = 0;
					cur_y++;
				end
				if (cur_y >= ROWS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++)
						screen_copy[i] = screen_copy[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						screen_copy[i] = blank;
					cur_y      = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_copy[i] = blank;
				cur_x = 0;
				cur_y = 0;
			end
			KIND_READ: begin
				if (int'(it.cell_address) < CELLS)
					r.cell_data = screen_copy[it.cell_address];
			end
			default: ;
		endcase
		r.cursor_column = 7'(cur_x);
		r.cursor_row    = 5'(cur_y);
		r.cursor_index  = 11'(cur_y * COLUMNS + cur_x);
		return r;
	endfunction

	function automatic directed_row_t drow(input logic [1:0] kind, input logic [7:0] ch,
			input logic [10:0] addr, input logic fixed, input int col, input int row,
			input logic [15:0] data);
		directed_row_t d;
		d.req.kind              = kind;
		d.req.char_code         = ch;
		d.req.cell_address      = addr;
		d.fixed                 = fixed;
		d.rsp.cursor_column     = 7'(col);
		d.rsp.cursor_row        = 5'(row);
		d.rsp.cursor_index      = 11'(row * COLUMNS + col);
		d.rsp.cell_data         = data;
		d.rsp.scrolled          = 1'b0;
		return d;
	endfunction

	// Offer one request beat; the sender pauses between bursts of random length
	task automatic send_req(input req_item_t it, input logic fixed, input rsp_item_t fixed_rsp);
		int        gap;
		rsp_item_t predicted;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (req_stall);
		predicted = console_step(it);
		awaited_rsps.push_back(fixed ? fixed_rsp : predicted);
	endtask

	// Drop valid and wait for every awaited report to come back
	task automatic finish_phase();
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0) @(posedge clk);
	endtask

	// Response side: check each accepted beat, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsps.size() == 0) begin
				$error("response beat with nothing awaited: %p", rsp_item);
				mismatch_count++;
			end else begin
				automatic rsp_item_t want = awaited_rsps.pop_front();
				if (rsp_item.cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, got %0d",
						want.cursor_column, rsp_item.cursor_column);
					mismatch_count++;
				end
				if (rsp_item.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d",
						want.cursor_row, rsp_item.cursor_row);
					mismatch_count++;
				end
				if (rsp_item.cursor_index !== want.cursor_index) begin
					$error("cursor_index: expected %0d, got %0d",
						want.cursor_index, rsp_item.cursor_index);
					mismatch_count++;
				end
				if (rsp_item.cell_data !== want.cell_data) begin
					$error("cell_data: expected 0x%04h, got 0x%04h",
						want.cell_data, rsp_item.cell_data);
					mismatch_count++;
				end
				if (rsp_item.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d",
						want.scrolled, rsp_item.scrolled);
					mismatch_count++;
				end
			end
		end
		// stall modes: open, light, heavy, periodic
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(20, 200);
		end
		stall_run--;
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ((stall_run % 3) == 0);
		endcase
	end

	initial begin
		req_item_t  it;
		int         pick;
		int         sel;
		logic [3:0] fg;
		logic [3:0] bg;

		// predictor reset state
		for (int i = 0; i < CELLS; i++)
			screen_copy[i] = RESET_CELL;
		cur_x   = 10;
		cur_y   = 0;
		fg_copy = FG_RESET;
		bg_copy = BG_RESET;

		directed_steps = '{
			drow(KIND_READ,   8'h00,      11'd0,    1'b1, 10, 0, RESET_CELL),
			drow(KIND_READ,   8'h00,      11'd1999, 1'b1, 10, 0, RESET_CELL),
			// read past the last cell
			drow(KIND_READ,   8'hFF,      11'h7FF,  1'b1, 10, 0, 16'h0000),
			drow(KIND_UNUSED, 8'hFF,      11'h7FF,  1'b1, 10, 0, 16'h0000),
			drow(KIND_PUT,    8'h41,      11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    8'hFF,      11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_SPACE, 11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    8'h00,      11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    8'h1F,      11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_BS,    11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_CR,    11'd0,    1'b0, 0, 0, 16'h0000),
			// backspace at column zero holds
			drow(KIND_PUT,    CHAR_BS,    11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_LF,    11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_READ,   8'h00,      11'd10,   1'b0, 0, 0, 16'h0000),
			drow(KIND_READ,   8'h00,      11'd12,   1'b0, 0, 0, 16'h0000),
			drow(KIND_CLEAR,  8'h00,      11'd0,    1'b1, 0, 0, 16'h0000),
			// nine tabs to column 72, the tenth wraps
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_PUT,    CHAR_TAB,   11'd0,    1'b0, 0, 0, 16'h0000),
			drow(KIND_READ,   8'h00,      11'd1999, 1'b0, 0, 0, 16'h0000)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part runs with the reset colors
		for (int i = 0; i < DIR_STEPS; i++)
			send_req(directed_steps[i].req, directed_steps[i].fixed, directed_steps[i].rsp);
		finish_phase();

		for (int p = 0; p < PHASES; p++) begin
			// extremes first, then random colors
			fg = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : (p == 2) ? 4'h0 : 4'($urandom_range(0, 15));
			bg = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : (p == 2) ? 4'hF : 4'($urandom_range(0, 15));
			cfg_write_en <= 1'b1;
			cfg_index    <= REG_FOREGROUND;
			cfg_data     <= fg;
			@(posedge clk);
			fg_copy = fg;
			cfg_index <= REG_BACKGROUND;
			cfg_data  <= bg;
			@(posedge clk);
			bg_copy = bg;
			cfg_write_en <= 1'b0;

			// mostly text with line breaks so the screen fills and scrolls
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick            = $urandom_range(0, 999);
				it.char_code    = 8'($urandom_range(0, 255));
				it.cell_address = 11'($urandom_range(0, 2047));
				if (pick < 3) begin
					it.kind = KIND_CLEAR;
				end else if (pick < 13) begin
					it.kind = KIND_UNUSED;
				end else if (pick < 213) begin
					it.kind = KIND_READ;
					if ($urandom_range(0, 9) != 0)
						it.cell_address = 11'($urandom_range(0, CELLS - 1));
				end else begin
					it.kind = KIND_PUT;
					sel     = $urandom_range(0, 99);
					if (sel < 20)
						it.char_code = CHAR_LF;
					else if (sel < 25)
						it.char_code = CHAR_TAB;
					else if (sel < 29)
						it.char_code = CHAR_CR;
					else if (sel < 34)
						it.char_code = CHAR_BS;
					else if (sel < 38)
						it.char_code = 8'($urandom_range(0, 31));
					else
						it.char_code = 8'($urandom_range(32, 255));
				end
				send_req(it, 1'b0, '0);
			end
			finish_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond every beat taking a full scroll sweep plus gaps and stalls
	initial begin
		#120000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
